// ===== design/mbta_pkg.sv =====
// Package for the motion blur tap average block.
// Shared constants and controller/datapath interface structs; no dependencies.
package mbta_pkg;

	localparam int DEF_MAX_LINE   = 512;
	localparam int DEF_MAX_TAPS   = 64;
	localparam int DEF_MAX_MARGIN = 33;
	localparam int MAX_HEIGHT     = 4096;
	localparam int CHANNELS       = 4;

	localparam int IMG_W_W = 10;
	localparam int IMG_H_W = 13;
	localparam int MARG_W  = 6;
	localparam int TCNT_W  = 7;
	localparam int CFG_W   = 13;
	localparam int OFS_W   = 8;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MARGIN = 2'd2;
	localparam logic [1:0] REG_TAPS   = 2'd3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	typedef struct packed {
		logic tap_wr;
		logic pix_wr;
		logic start;
		logic tap_rd;
		logic div_init;
		logic div_step;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic produce;
		logic pipe_busy;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== design/mbta_ctrl.sv =====
// Controller state machine for the motion blur tap average block.
// Depends on mbta_pkg; drives the datapath through ctl_cmd_t.
module mbta_ctrl #(
	parameter int MAX_TAPS = mbta_pkg::DEF_MAX_TAPS,
	parameter int N_W      = 7,
	parameter int SUM_W    = 14,
	parameter int TI_W     = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  mbta_pkg::ctl_sts_t  sts,
	input  logic [N_W-1:0]      n_taps,
	output mbta_pkg::ctl_cmd_t  cmd,
	output logic [TI_W-1:0]     tap_idx
);

	localparam int CNT_W = (N_W > $clog2(SUM_W + 1)) ? N_W : $clog2(SUM_W + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RUN   = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign tap_idx  = cnt_q[TI_W-1:0];

	always_comb begin
		cmd          = '0;
		cmd.tap_wr   = accept && (command == mbta_pkg::CMD_LOAD);
		cmd.pix_wr   = accept && (command == mbta_pkg::CMD_PIXEL);
		cmd.start    = cmd.pix_wr && sts.produce;
		cmd.tap_rd   = (state_q == ST_RUN);
		cmd.div_init = (state_q == ST_DRAIN) && !sts.pipe_busy;
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_OUT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd.start) state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(n_taps) - CNT_W'(1)) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					cnt_q <= '0;
					if (!sts.pipe_busy) state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SUM_W - 1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/mbta_dpath.sv =====
// Datapath for the motion blur tap average block: registers, frame position,
// tap table, line store, accumulators, divider and result register. Uses mbta_pkg.
module mbta_dpath #(
	parameter int MAX_LINE   = mbta_pkg::DEF_MAX_LINE,
	parameter int MAX_TAPS   = mbta_pkg::DEF_MAX_TAPS,
	parameter int MAX_MARGIN = mbta_pkg::DEF_MAX_MARGIN,
	parameter int N_W        = 7,
	parameter int SUM_W      = 14,
	parameter int TI_W       = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [mbta_pkg::CFG_W-1:0] cfg_data,
	input  logic [5:0]           tap_index,
	input  logic signed [6:0]    tap_dx,
	input  logic signed [6:0]    tap_dy,
	input  logic [7:0]           in_blue,
	input  logic [7:0]           in_green,
	input  logic [7:0]           in_red,
	input  logic [7:0]           in_alpha,
	input  mbta_pkg::ctl_cmd_t   cmd,
	input  logic [TI_W-1:0]      tap_idx,
	output mbta_pkg::ctl_sts_t   sts,
	output logic [N_W-1:0]       n_taps,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_blue,
	output logic [7:0]           out_green,
	output logic [7:0]           out_red,
	output logic [7:0]           out_alpha,
	output logic [8:0]           out_col,
	output logic [11:0]          out_row,
	output logic                 frame_done
);

	localparam int STORE_ROWS = 2 * MAX_MARGIN + 1;
	localparam int STORE_COLS = MAX_LINE + 2 * MAX_MARGIN;
	localparam int DEPTH      = STORE_ROWS * STORE_COLS;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int COL_W      = $clog2(STORE_COLS + 1);
	localparam int ROW_W      = $clog2(mbta_pkg::MAX_HEIGHT + 2 * MAX_MARGIN + 1);
	localparam int RM_W       = $clog2(STORE_ROWS);
	localparam int WC_W       = (COL_W > mbta_pkg::IMG_W_W) ? COL_W : mbta_pkg::IMG_W_W;
	localparam int RB_W       = RM_W + 2;
	localparam int OW         = mbta_pkg::OFS_W;

	// configuration
	logic [mbta_pkg::IMG_W_W-1:0] width_q;
	logic [mbta_pkg::IMG_H_W-1:0] height_q;
	logic [mbta_pkg::MARG_W-1:0]  margin_q;
	logic [mbta_pkg::TCNT_W-1:0]  taps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mbta_pkg::IMG_W_W'(64);
			height_q <= mbta_pkg::IMG_H_W'(64);
			margin_q <= mbta_pkg::MARG_W'(4);
			taps_q   <= mbta_pkg::TCNT_W'(6);
		end else if (cfg_we) begin
			case (cfg_index)
				mbta_pkg::REG_WIDTH:  width_q  <= cfg_data[mbta_pkg::IMG_W_W-1:0];
				mbta_pkg::REG_HEIGHT: height_q <= cfg_data[mbta_pkg::IMG_H_W-1:0];
				mbta_pkg::REG_MARGIN: margin_q <= cfg_data[mbta_pkg::MARG_W-1:0];
				mbta_pkg::REG_TAPS:   taps_q   <= cfg_data[mbta_pkg::TCNT_W-1:0];
				default: ;
			endcase
		end
	end

	logic [WC_W-1:0]                 w_ext;
	logic [COL_W-1:0]                w_cl, pw;
	logic [ROW_W-1:0]                h_cl, ph;
	logic [mbta_pkg::MARG_W-1:0]     m;
	logic [N_W-1:0]                  n_ext;

	always_comb begin
		w_ext = WC_W'(width_q);
		if (w_ext == '0) w_cl = COL_W'(1);
		else if (w_ext > WC_W'(MAX_LINE)) w_cl = COL_W'(MAX_LINE);
		else w_cl = COL_W'(w_ext);
		if (height_q == '0) h_cl = ROW_W'(1);
		else if (height_q > mbta_pkg::IMG_H_W'(mbta_pkg::MAX_HEIGHT))
			h_cl = ROW_W'(mbta_pkg::MAX_HEIGHT);
		else h_cl = ROW_W'(height_q);
		m = (32'(margin_q) > MAX_MARGIN) ? mbta_pkg::MARG_W'(MAX_MARGIN) : margin_q;
		pw = w_cl + COL_W'({m, 1'b0});
		ph = h_cl + ROW_W'({m, 1'b0});
		n_ext = N_W'(taps_q);
		if (n_ext == '0) n_taps = N_W'(1);
		else if (n_ext > N_W'(MAX_TAPS)) n_taps = N_W'(MAX_TAPS);
		else n_taps = n_ext;
	end

	// frame position
	logic [COL_W-1:0] pcol_q, pc;
	logic [ROW_W-1:0] prow_q, pr;
	logic [RM_W-1:0]  rmod_q, rm;
	logic             produce;

	always_comb begin
		pc = (pcol_q >= pw) ? '0 : pcol_q;
		pr = (prow_q >= ph) ? '0 : prow_q;
		rm = (prow_q >= ph) ? '0 : rmod_q;
		produce = (pc >= COL_W'({m, 1'b0})) && (pr >= ROW_W'({m, 1'b0}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcol_q <= '0;
			prow_q <= '0;
			rmod_q <= '0;
		end else if (cmd.pix_wr) begin
			if (pc + COL_W'(1) >= pw) begin
				pcol_q <= '0;
				if (pr + ROW_W'(1) >= ph) begin
					prow_q <= '0;
					rmod_q <= '0;
				end else begin
					prow_q <= pr + ROW_W'(1);
					rmod_q <= (rm == RM_W'(STORE_ROWS - 1)) ? '0 : rm + RM_W'(1);
				end
			end else begin
				pcol_q <= pc + COL_W'(1);
			end
		end
	end

	// context of the pixel being worked on
	logic [COL_W-1:0]         cc_q;
	logic signed [RB_W-1:0]   rb_q;
	logic [8:0]               col_q;
	logic [11:0]              row_q;
	logic                     done_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cc_q   <= pc - COL_W'(m);
			rb_q   <= $signed(RB_W'(rm)) - $signed(RB_W'(m));
			col_q  <= 9'(pc - COL_W'({m, 1'b0}));
			row_q  <= 12'(pr - ROW_W'({m, 1'b0}));
			done_q <= (pc == pw - COL_W'(1)) && (pr == ph - ROW_W'(1));
		end
	end

	// tap table
	logic [13:0]         tap_mem [MAX_TAPS];
	logic [13:0]         tap_s1;
	logic                v_s1;

	always_ff @(posedge clk) begin
		if (cmd.tap_wr && (32'(tap_index) < MAX_TAPS))
			tap_mem[TI_W'(tap_index)] <= {tap_dx, tap_dy};
		if (cmd.tap_rd)
			tap_s1 <= tap_mem[tap_idx];
	end

	// tap address
	logic signed [OW-1:0]      ms, dx, dy, dxc, dyc;
	logic signed [COL_W:0]     col_s;
	logic signed [RB_W-1:0]    row_s;
	logic [RM_W-1:0]           row_m;
	logic [ADDR_W-1:0]         rd_addr, wr_addr;

	always_comb begin
		ms = $signed(OW'(m));
		dx = OW'(signed'(tap_s1[13:7]));
		dy = OW'(signed'(tap_s1[6:0]));
		dxc = (dx < -ms) ? -ms : ((dx > ms) ? ms : dx);
		dyc = (dy < -ms) ? -ms : ((dy > ms) ? ms : dy);
		col_s = $signed({1'b0, cc_q}) + (COL_W+1)'(dxc);
		row_s = rb_q + RB_W'(dyc);
		if (row_s < 0) row_s = row_s + RB_W'(STORE_ROWS);
		row_m = row_s[RM_W-1:0];
		rd_addr = ADDR_W'(row_m * STORE_COLS) + ADDR_W'(col_s[COL_W-1:0]);
		wr_addr = ADDR_W'(rm * STORE_COLS) + ADDR_W'(pc);
	end

	// line store
	logic [31:0] line_mem [DEPTH];
	logic [31:0] pix_s2;
	logic        v_s2;

	always_ff @(posedge clk) begin
		if (cmd.pix_wr)
			line_mem[wr_addr] <= {in_alpha, in_red, in_green, in_blue};
		if (v_s1)
			pix_s2 <= line_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.tap_rd;
			v_s2 <= v_s1;
		end
	end

	// accumulate and divide
	logic [SUM_W-1:0] acc_q [mbta_pkg::CHANNELS];
	logic [SUM_W-1:0] quo_q [mbta_pkg::CHANNELS];
	logic [N_W:0]     rem_q [mbta_pkg::CHANNELS];
	logic [N_W:0]     rem_t [mbta_pkg::CHANNELS];
	logic             fit   [mbta_pkg::CHANNELS];

	always_comb begin
		for (int c = 0; c < mbta_pkg::CHANNELS; c++) begin
			rem_t[c] = {rem_q[c][N_W-1:0], quo_q[c][SUM_W-1]};
			fit[c]   = rem_t[c] >= {1'b0, n_taps};
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < mbta_pkg::CHANNELS; c++) begin
			if (cmd.start)
				acc_q[c] <= '0;
			else if (v_s2)
				acc_q[c] <= acc_q[c] + SUM_W'(pix_s2[8*c +: 8]);
			if (cmd.div_init) begin
				quo_q[c] <= acc_q[c];
				rem_q[c] <= '0;
			end else if (cmd.div_step) begin
				quo_q[c] <= {quo_q[c][SUM_W-2:0], fit[c]};
				rem_q[c] <= fit[c] ? rem_t[c] - {1'b0, n_taps} : rem_t[c];
			end
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_blue   <= quo_q[0][7:0];
			out_green  <= quo_q[1][7:0];
			out_red    <= quo_q[2][7:0];
			out_alpha  <= quo_q[3][7:0];
			out_col    <= col_q;
			out_row    <= row_q;
			frame_done <= done_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.produce   = produce;
	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule

// ===== design/motion_blur_tap_average_core.sv =====
// Top level of the motion blur tap average block: controller plus datapath.
// Depends on mbta_pkg, mbta_ctrl and mbta_dpath.
//
//  channel  dir  handshake          payload
//  in       in   in_valid/in_stall  command, tap_index, tap_dx, tap_dy, in_blue..in_alpha
//  out      out  out_valid/out_stall out_blue..out_alpha, out_col, out_row, frame_done
//  cfg      in   cfg_we             cfg_index, cfg_data
//
// Load items and pixels that give no result do not raise in_stall.
// A pixel with a result is read one tap a cycle through the tap table and line
// store read ports, then runs a restoring divider one quotient bit a cycle.
// in_stall is high meanwhile.
// The result register lets the next item in while a result waits on out_stall.
// Reset clears control and position; the line store and tap table are not cleared.
module motion_blur_tap_average_core #(
	parameter int MAX_LINE   = mbta_pkg::DEF_MAX_LINE,
	parameter int MAX_TAPS   = mbta_pkg::DEF_MAX_TAPS,
	parameter int MAX_MARGIN = mbta_pkg::DEF_MAX_MARGIN
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [mbta_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       command,
	input  logic [5:0]                 tap_index,
	input  logic signed [6:0]          tap_dx,
	input  logic signed [6:0]          tap_dy,
	input  logic [7:0]                 in_blue,
	input  logic [7:0]                 in_green,
	input  logic [7:0]                 in_red,
	input  logic [7:0]                 in_alpha,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_blue,
	output logic [7:0]                 out_green,
	output logic [7:0]                 out_red,
	output logic [7:0]                 out_alpha,
	output logic [8:0]                 out_col,
	output logic [11:0]                out_row,
	output logic                       frame_done
);

	localparam int N_W   = ($clog2(MAX_TAPS + 1) > mbta_pkg::TCNT_W) ?
		$clog2(MAX_TAPS + 1) : mbta_pkg::TCNT_W;
	localparam int SUM_W = $clog2(MAX_TAPS * 255 + 1);
	localparam int TI_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	mbta_pkg::ctl_cmd_t cmd;
	mbta_pkg::ctl_sts_t sts;
	logic [N_W-1:0]     n_taps;
	logic [TI_W-1:0]    tap_idx;

	mbta_ctrl #(
		.MAX_TAPS(MAX_TAPS),
		.N_W(N_W),
		.SUM_W(SUM_W),
		.TI_W(TI_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.sts(sts),
		.n_taps(n_taps),
		.cmd(cmd),
		.tap_idx(tap_idx)
	);

	mbta_dpath #(
		.MAX_LINE(MAX_LINE),
		.MAX_TAPS(MAX_TAPS),
		.MAX_MARGIN(MAX_MARGIN),
		.N_W(N_W),
		.SUM_W(SUM_W),
		.TI_W(TI_W)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tap_index(tap_index),
		.tap_dx(tap_dx),
		.tap_dy(tap_dy),
		.in_blue(in_blue),
		.in_green(in_green),
		.in_red(in_red),
		.in_alpha(in_alpha),
		.cmd(cmd),
		.tap_idx(tap_idx),
		.sts(sts),
		.n_taps(n_taps),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_blue(out_blue),
		.out_green(out_green),
		.out_red(out_red),
		.out_alpha(out_alpha),
		.out_col(out_col),
		.out_row(out_row),
		.frame_done(frame_done)
	);

endmodule
